// File: src/trun_pkg.sv
// Package for the triangle unit normal block: widths, lane types and result math.
// Used by the channel interfaces, the setup pipe, the normalizer cells and the top level.
package trun_pkg;
   localparam int COORD_BITS = 16;
   localparam int FRAC_BITS  = 14;
   localparam int EDGE_BITS  = COORD_BITS + 1;
   localparam int PROD_BITS  = 2 * EDGE_BITS;
   localparam int CROSS_BITS = PROD_BITS + 1;
   localparam int MAG_BITS   = PROD_BITS;
   localparam int SQ_BITS    = 2 * MAG_BITS;
   localparam int LEN_BITS   = SQ_BITS + 2;
   localparam int WORK_BITS  = LEN_BITS + 2 * FRAC_BITS + 3;
   localparam int QUO_BITS   = FRAC_BITS + 1;
   localparam int OUT_BITS   = FRAC_BITS + 2;
   localparam int STEPS      = FRAC_BITS + 1;
   localparam int STEP_BITS  = $clog2(STEPS);

   typedef struct packed {
      logic [WORK_BITS-1:0] rem;
      logic [WORK_BITS-1:0] acc;
      logic [QUO_BITS-1:0]  quo;
   } comp_type;

   typedef struct packed {
      logic                valid;
      logic                degenerate;
      logic [2:0]          neg;
      logic [LEN_BITS-1:0] len2;
      comp_type [2:0]      comp;
   } lane_type;
endpackage

// File: src/trun_if.sv
// Valid/ready channel interfaces for triangle beats and normal beats.
// Depends on trun_pkg for the field widths.
interface trun_req_if;
   logic valid;
   logic ready;
   logic signed [trun_pkg::COORD_BITS-1:0] a_x, a_y, a_z, b_x, b_y, b_z, c_x, c_y, c_z;
   modport source (output valid, a_x, a_y, a_z, b_x, b_y, b_z, c_x, c_y, c_z, input ready);
   modport sink (input valid, a_x, a_y, a_z, b_x, b_y, b_z, c_x, c_y, c_z, output ready);
endinterface

interface trun_rsp_if;
   logic valid;
   logic ready;
   logic signed [trun_pkg::OUT_BITS-1:0] normal_x, normal_y, normal_z;
   logic degenerate;
   modport source (output valid, normal_x, normal_y, normal_z, degenerate, input ready);
   modport sink (input valid, normal_x, normal_y, normal_z, degenerate, output ready);
endinterface

// File: src/trun_setup.sv
// Setup pipe: edges, cross product, magnitudes, squares and squared length.
// Depends on trun_pkg; feeds the first normalizer cell.
module trun_setup (
   input  logic clock,
   input  logic reset,
   input  logic advance,
   input  logic in_valid,
   input  logic signed [trun_pkg::COORD_BITS-1:0] ax, ay, az, bx, by, bz, cx, cy, cz,
   output trun_pkg::lane_type lane_out
);
   import trun_pkg::*;

   logic [3:0] valid_ff;
   logic signed [EDGE_BITS-1:0] e1_ff [3];
   logic signed [EDGE_BITS-1:0] e2_ff [3];
   logic signed [PROD_BITS-1:0] prod_ff [6];
   logic [MAG_BITS-1:0] mag_ff [3];
   logic [2:0] neg_ff, neg2_ff;
   logic deg_ff, deg2_ff;
   logic [SQ_BITS-1:0] sq_ff [3];
   logic signed [CROSS_BITS-1:0] cross_in [3];
   lane_type lane_in, lane_ff;

   always_comb begin
      cross_in[0] = CROSS_BITS'(prod_ff[0]) - CROSS_BITS'(prod_ff[1]);
      cross_in[1] = CROSS_BITS'(prod_ff[2]) - CROSS_BITS'(prod_ff[3]);
      cross_in[2] = CROSS_BITS'(prod_ff[4]) - CROSS_BITS'(prod_ff[5]);
      lane_in.valid      = valid_ff[3];
      lane_in.degenerate = deg2_ff;
      lane_in.neg        = neg2_ff;
      lane_in.len2       = LEN_BITS'(sq_ff[0]) + LEN_BITS'(sq_ff[1]) + LEN_BITS'(sq_ff[2]);
      for (int i = 0; i < 3; i++) begin
         lane_in.comp[i].rem = WORK_BITS'(sq_ff[i]) << (2 * FRAC_BITS);
         lane_in.comp[i].acc = '0;
         lane_in.comp[i].quo = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff      <= '0;
         lane_ff.valid <= 1'b0;
      end else if (advance) begin
         valid_ff <= {valid_ff[2:0], in_valid};
         e1_ff[0] <= EDGE_BITS'(bx) - EDGE_BITS'(ax);
         e1_ff[1] <= EDGE_BITS'(by) - EDGE_BITS'(ay);
         e1_ff[2] <= EDGE_BITS'(bz) - EDGE_BITS'(az);
         e2_ff[0] <= EDGE_BITS'(cx) - EDGE_BITS'(ax);
         e2_ff[1] <= EDGE_BITS'(cy) - EDGE_BITS'(ay);
         e2_ff[2] <= EDGE_BITS'(cz) - EDGE_BITS'(az);
         prod_ff[0] <= e1_ff[1] * e2_ff[2];
         prod_ff[1] <= e1_ff[2] * e2_ff[1];
         prod_ff[2] <= e1_ff[2] * e2_ff[0];
         prod_ff[3] <= e1_ff[0] * e2_ff[2];
         prod_ff[4] <= e1_ff[0] * e2_ff[1];
         prod_ff[5] <= e1_ff[1] * e2_ff[0];
         for (int i = 0; i < 3; i++) begin
            neg_ff[i] <= cross_in[i][CROSS_BITS-1];
            mag_ff[i] <= cross_in[i][CROSS_BITS-1] ? MAG_BITS'(-cross_in[i])
                                                   : MAG_BITS'(cross_in[i]);
            sq_ff[i]  <= mag_ff[i] * mag_ff[i];
         end
         deg_ff  <= (cross_in[0] == '0) && (cross_in[1] == '0) && (cross_in[2] == '0);
         deg2_ff <= deg_ff;
         neg2_ff <= neg_ff;
         lane_ff <= lane_in;
      end
   end

   assign lane_out = lane_ff;
endmodule

// File: src/trun_cell.sv
// Normalizer cell: settles one quotient bit of all three components per beat.
// Depends on trun_pkg; cells are chained by the top level.
module trun_cell (
   input  logic clock,
   input  logic reset,
   input  logic advance,
   input  logic [trun_pkg::STEP_BITS-1:0] step_bit,
   input  trun_pkg::lane_type lane_up,
   output trun_pkg::lane_type lane_dn
);
   import trun_pkg::*;

   lane_type lane_in, lane_ff;
   logic [WORK_BITS-1:0] len_w;
   logic [WORK_BITS-1:0] cand [3];

   // With q the bits settled so far, rem holds c^2*2^2F - q^2*L and acc holds q*L.
   always_comb begin
      lane_in = lane_up;
      len_w   = WORK_BITS'(lane_up.len2);
      for (int i = 0; i < 3; i++) begin
         cand[i] = ((lane_up.comp[i].acc << step_bit) << 1) + ((len_w << step_bit) << step_bit);
         if (lane_up.comp[i].rem >= cand[i]) begin
            lane_in.comp[i].rem = lane_up.comp[i].rem - cand[i];
            lane_in.comp[i].acc = lane_up.comp[i].acc + (len_w << step_bit);
            lane_in.comp[i].quo = lane_up.comp[i].quo | (QUO_BITS'(1) << step_bit);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         lane_ff.valid <= 1'b0;
      end else if (advance) begin
         lane_ff <= lane_in;
      end
   end

   assign lane_dn = lane_ff;
endmodule

// File: src/triangle_unit_normal_top.sv
// Top level of the triangle unit normal block: setup pipe, cell chain, output register.
// Depends on trun_pkg, trun_if, trun_setup and trun_cell.
//
//   channel | dir | beat contents
//   req     | in  | vertices A, B, C (a_x .. c_z)
//   rsp     | out | normal_x, normal_y, normal_z, degenerate
//
// One triangle per cycle is accepted while the pipe is not held; each passes from req to rsp through
// five setup stages, one cell per quotient bit (15), and the output register.
// Reset clears only the valid bits of the pipe.
// The whole pipe holds while a result waits on rsp; req.ready follows that.
module triangle_unit_normal_top (
   input  logic clock,
   input  logic reset,
   trun_req_if.sink   req,
   trun_rsp_if.source rsp
);
   import trun_pkg::*;

   logic advance;
   lane_type lane [STEPS+1];
   logic out_valid_ff;
   logic signed [OUT_BITS-1:0] norm_ff [3];
   logic signed [OUT_BITS-1:0] norm_in [3];
   logic deg_ff;

   assign advance   = !out_valid_ff || rsp.ready;
   assign req.ready = advance;

   trun_setup u_setup (
      .clock(clock), .reset(reset), .advance(advance), .in_valid(req.valid),
      .ax(req.a_x), .ay(req.a_y), .az(req.a_z),
      .bx(req.b_x), .by(req.b_y), .bz(req.b_z),
      .cx(req.c_x), .cy(req.c_y), .cz(req.c_z),
      .lane_out(lane[0])
   );

   for (genvar k = 0; k < STEPS; k++) begin : g_cell
      trun_cell u_cell (
         .clock(clock), .reset(reset), .advance(advance),
         .step_bit(STEP_BITS'(FRAC_BITS - k)),
         .lane_up(lane[k]), .lane_dn(lane[k+1])
      );
   end

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         if (lane[STEPS].degenerate) begin
            norm_in[i] = '0;
         end else if (lane[STEPS].neg[i]) begin
            norm_in[i] = -OUT_BITS'(lane[STEPS].comp[i].quo);
         end else begin
            norm_in[i] = OUT_BITS'(lane[STEPS].comp[i].quo);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (advance) begin
         out_valid_ff <= lane[STEPS].valid;
         norm_ff      <= norm_in;
         deg_ff       <= lane[STEPS].degenerate;
      end
   end

   assign rsp.valid      = out_valid_ff;
   assign rsp.normal_x   = norm_ff[0];
   assign rsp.normal_y   = norm_ff[1];
   assign rsp.normal_z   = norm_ff[2];
   assign rsp.degenerate = deg_ff;

`ifndef ASSERT_OFF
   localparam logic signed [OUT_BITS-1:0] One = OUT_BITS'(1) << FRAC_BITS;

   a_deg_zero: assert property (@(posedge clock) disable iff (reset)
      rsp.valid && rsp.degenerate |->
         rsp.normal_x == '0 && rsp.normal_y == '0 && rsp.normal_z == '0)
      else $error("degenerate beat with nonzero normal");

   a_unit_range: assert property (@(posedge clock) disable iff (reset)
      rsp.valid |-> rsp.normal_x <= One && rsp.normal_x >= -One &&
         rsp.normal_y <= One && rsp.normal_y >= -One &&
         rsp.normal_z <= One && rsp.normal_z >= -One)
      else $error("normal component out of unit range");

   a_reset_empty: assert property (@(posedge clock)
      $past(reset) |-> !rsp.valid)
      else $error("result valid right after reset");
`endif
endmodule

// File: tb/triangle_unit_normal_top_tb.sv
// Testbench for triangle_unit_normal_top: directed and random triangles with random stalls.
// A scoreboard predicts each unit normal and compares it field by field.
// Depends on trun_pkg, trun_if and the RTL of the top level.
`timescale 1ns / 1ps

module triangle_unit_normal_top_tb;
   import trun_pkg::*;

   localparam int  RANDOM_TRIANGLES = 1250;
   localparam int  CYCLE_LIMIT      = 400000;
   localparam int  DRAIN_CYCLES     = 30;
   localparam int  CALM_FIRST       = 500;
   localparam int  CALM_LAST        = 800;
   localparam int  PAUSE_AT         = 900;

   typedef logic signed [COORD_BITS-1:0] coord_type;
   typedef logic signed [OUT_BITS-1:0]   comp_type;

   typedef struct packed {
      coord_type a_x, a_y, a_z, b_x, b_y, b_z, c_x, c_y, c_z;
   } triangle_type;

   typedef struct packed {
      comp_type normal_x, normal_y, normal_z;
      logic     degenerate;
   } normal_type;

   class normal_scoreboard;
      normal_type pending[$];
      int         errors;

      function normal_type unit_normal(triangle_type t);
         longint      e1[3], e2[3], n[3];
         logic [127:0] m[3];
         logic [127:0] len2, target, q, cand;
         comp_type    r[3];
         normal_type  res;
         e1[0] = longint'(t.b_x) - longint'(t.a_x);
         e1[1] = longint'(t.b_y) - longint'(t.a_y);
         e1[2] = longint'(t.b_z) - longint'(t.a_z);
         e2[0] = longint'(t.c_x) - longint'(t.a_x);
         e2[1] = longint'(t.c_y) - longint'(t.a_y);
         e2[2] = longint'(t.c_z) - longint'(t.a_z);
         n[0] = e1[1] * e2[2] - e1[2] * e2[1];
         n[1] = e1[2] * e2[0] - e1[0] * e2[2];
         n[2] = e1[0] * e2[1] - e1[1] * e2[0];
         if (n[0] == 0 && n[1] == 0 && n[2] == 0) begin
            res = '0;
            res.degenerate = 1'b1;
            return res;
         end
         len2 = '0;
         for (int i = 0; i < 3; i++) begin
            m[i] = (n[i] < 0) ? 128'(-n[i]) : 128'(n[i]);
            len2 = len2 + m[i] * m[i];
         end
         for (int i = 0; i < 3; i++) begin
            target = (m[i] * m[i]) << (2 * FRAC_BITS);
            q = '0;
            for (int b = FRAC_BITS; b >= 0; b--) begin
               cand = q | (128'(1) << b);
               if (cand * cand * len2 <= target) q = cand;
            end
            r[i] = (n[i] < 0) ? -comp_type'(q) : comp_type'(q);
         end
         res.normal_x = r[0];
         res.normal_y = r[1];
         res.normal_z = r[2];
         res.degenerate = 1'b0;
         return res;
      endfunction

      function void note(triangle_type t);
         pending.push_back(unit_normal(t));
      endfunction

      function void check(normal_type got);
         normal_type exp;
         if (pending.size() == 0) begin
            $error("unexpected normal beat %h", got);
            errors++;
            return;
         end
         exp = pending.pop_front();
         if (got.normal_x !== exp.normal_x) begin
            $error("normal_x expected %0d actual %0d", exp.normal_x, got.normal_x);
            errors++;
         end
         if (got.normal_y !== exp.normal_y) begin
            $error("normal_y expected %0d actual %0d", exp.normal_y, got.normal_y);
            errors++;
         end
         if (got.normal_z !== exp.normal_z) begin
            $error("normal_z expected %0d actual %0d", exp.normal_z, got.normal_z);
            errors++;
         end
         if (got.degenerate !== exp.degenerate) begin
            $error("degenerate expected %0d actual %0d", exp.degenerate, got.degenerate);
            errors++;
         end
      endfunction
   endclass

   logic clock;
   logic reset;
   int   cycles;
   int   sent;
   normal_scoreboard normals;

   trun_req_if req ();
   trun_rsp_if rsp ();

   triangle_unit_normal_top dut (
      .clock (clock),
      .reset (reset),
      .req   (req.sink),
      .rsp   (rsp.source)
   );

   always begin
      clock = 1'b1;
      #5;
      clock = 1'b0;
      #5;
   end

   function automatic bit calm();
      return sent >= CALM_FIRST && sent < CALM_LAST;
   endfunction

   function automatic triangle_type make_triangle(coord_type ax, coord_type ay, coord_type az,
                                                  coord_type bx, coord_type by, coord_type bz,
                                                  coord_type cx, coord_type cy, coord_type cz);
      triangle_type t;
      t = '{ax, ay, az, bx, by, bz, cx, cy, cz};
      return t;
   endfunction

   function automatic coord_type near(int centre, int span);
      return coord_type'(centre + $urandom_range(2 * span) - span);
   endfunction

   function automatic triangle_type random_triangle();
      triangle_type t;
      int           pick, ax, ay, az, dx, dy, dz, k;
      pick = $urandom_range(99);
      t = triangle_type'({$urandom, $urandom, $urandom, $urandom, $urandom});
      if (pick < 20) begin
         ax = $urandom_range(200) - 100;
         ay = $urandom_range(200) - 100;
         az = $urandom_range(200) - 100;
         t = make_triangle(coord_type'(ax), coord_type'(ay), coord_type'(az),
                           near(ax, 8), near(ay, 8), near(az, 8),
                           near(ax, 8), near(ay, 8), near(az, 8));
      end else if (pick < 30) begin
         t.b_z = t.a_z;
         t.c_z = t.a_z;
         if (pick < 25) begin
            t.b_y = t.a_y;
            t.c_x = t.a_x;
         end
      end else if (pick < 40) begin
         ax = $urandom_range(20000) - 10000;
         ay = $urandom_range(20000) - 10000;
         az = $urandom_range(20000) - 10000;
         dx = $urandom_range(200) - 100;
         dy = $urandom_range(200) - 100;
         dz = $urandom_range(200) - 100;
         k = $urandom_range(40) - 20;
         t = make_triangle(coord_type'(ax), coord_type'(ay), coord_type'(az),
                           coord_type'(ax + dx), coord_type'(ay + dy), coord_type'(az + dz),
                           coord_type'(ax + k * dx), coord_type'(ay + k * dy),
                           coord_type'(az + k * dz));
         if (pick < 33) t.c_x = t.b_x;
         if (pick < 33) begin
            t.c_y = t.b_y;
            t.c_z = t.b_z;
         end
      end
      return t;
   endfunction

   task automatic send_triangle(triangle_type t);
      while (!calm() && $urandom_range(99) < 21) begin
         req.valid <= 1'b0;
         @(posedge clock);
      end
      req.valid <= 1'b1;
      {req.a_x, req.a_y, req.a_z, req.b_x, req.b_y, req.b_z,
       req.c_x, req.c_y, req.c_z} <= t;
      @(negedge clock);
      while (!req.ready) @(negedge clock);
      @(posedge clock);
      normals.note(t);
      sent++;
   endtask

   always @(posedge clock) begin
      if (calm()) begin
         rsp.ready <= 1'b1;
      end else begin
         rsp.ready <= ($urandom_range(99) >= 21);
      end
   end

   always @(negedge clock) begin
      if (!reset && rsp.valid && rsp.ready) begin
         normals.check({rsp.normal_x, rsp.normal_y, rsp.normal_z, rsp.degenerate});
      end
   end

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > CYCLE_LIMIT) begin
         $display("== FAIL ==");
         $finish;
      end
   end

   initial begin
      triangle_type directed[$];
      normals = new();
      cycles = 0;
      sent = 0;
      reset = 1'b1;
      req.valid = 1'b0;
      rsp.ready = 1'b0;
      {req.a_x, req.a_y, req.a_z, req.b_x, req.b_y, req.b_z,
       req.c_x, req.c_y, req.c_z} = '0;
      directed.push_back(make_triangle(0, 0, 0, 0, 0, 0, 0, 0, 0));
      directed.push_back(make_triangle(5, 6, 7, 5, 6, 7, 5, 6, 7));
      directed.push_back(make_triangle(1, 1, 1, 2, 2, 2, 3, 3, 3));
      directed.push_back(make_triangle(0, 0, 0, 1, 0, 0, 0, 1, 0));
      directed.push_back(make_triangle(0, 0, 0, 0, 1, 0, 1, 0, 0));
      directed.push_back(make_triangle(0, 0, 0, 0, 1, 0, 0, 0, 1));
      directed.push_back(make_triangle(0, 0, 0, 0, 0, 1, 1, 0, 0));
      directed.push_back(make_triangle(-32768, -32768, -32768, 32767, -32768, -32768,
                                       -32768, 32767, -32768));
      directed.push_back(make_triangle(32767, 32767, 32767, -32768, 32767, 32767,
                                       32767, -32768, 32767));
      directed.push_back(make_triangle(-32768, -32768, -32768, 32767, 32767, -32768,
                                       -32768, 32767, 32767));
      directed.push_back(make_triangle(32767, -32768, 32767, -32768, 32767, -32768,
                                       32767, 32767, -32768));
      directed.push_back(make_triangle(-32768, 32767, -32768, 32767, -32768, 32767,
                                       -32768, -32768, 32767));
      directed.push_back(make_triangle(0, 0, 0, 1, 1, 0, 1, 0, 1));
      directed.push_back(make_triangle(0, 0, 0, 3, 0, 0, 0, 4, 0));
      directed.push_back(make_triangle(0, 0, 0, 1, 2, 3, -1, -2, -3));
      directed.push_back(make_triangle(-1, -1, -1, -1, -1, -1, 0, 0, 0));
      directed.push_back(make_triangle(100, 200, 300, 101, 200, 300, 100, 200, 301));
      directed.push_back(make_triangle(-32768, 0, 0, 32767, 1, 0, 0, 0, 1));
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      foreach (directed[i]) send_triangle(directed[i]);
      for (int i = 0; i < RANDOM_TRIANGLES; i++) begin
         if (i == PAUSE_AT) begin
            req.valid <= 1'b0;
            @(posedge clock);
            while (normals.pending.size() != 0) @(posedge clock);
         end
         send_triangle(random_triangle());
      end
      req.valid <= 1'b0;
      while (normals.pending.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (normals.errors == 0) begin
         $display("== PASS ==");
      end else begin
         $display("== FAIL ==");
      end
      $finish;
   end
endmodule
